// ===== design/ccps_pkg.sv =====
// Shared types, constants and helpers of the corner-cutting path smoother.
`default_nettype none
package ccps_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int MAX_PASSES  = 6;
  localparam int LVL_W       = 3;
  localparam int RATIO_W     = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int QUEUE_DEPTH = 3;

  localparam logic [RATIO_W-1:0] RATIO_MIN   = 15'd1311;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'd29491;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd16384;
  localparam logic [LVL_W-1:0]   PASS_LIMIT  = 3'd6;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_PASSES = 2'd1,
    REG_RATIO  = 2'd2
  } cfg_reg_t;

  function automatic coord_t coord_get(input point_t p, input logic [1:0] idx);
    coord_t v;
    unique case (idx)
      2'd0:    v = p.x;
      2'd1:    v = p.y;
      default: v = p.z;
    endcase
    return v;
  endfunction

  function automatic point_t coord_set(input point_t p, input logic [1:0] idx,
                                       input coord_t v);
    point_t r;
    r = p;
    unique case (idx)
      2'd0:    r.x = v;
      2'd1:    r.y = v;
      default: r.z = v;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/ccps_if.sv =====
// Valid/ready channel interfaces for input points and packed result words.
`default_nettype none
interface ccps_in_if import ccps_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  logic   path_last;
  modport source (output valid, in_x, in_y, in_z, path_last, input ready);
  modport sink   (input valid, in_x, in_y, in_z, path_last, output ready);
endinterface

interface ccps_out_if import ccps_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_t     first_x;
  coord_t     first_y;
  coord_t     first_z;
  coord_t     second_x;
  coord_t     second_y;
  coord_t     second_z;
  logic [1:0] point_count;
  logic       run_last;
  logic       path_end;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, point_count, run_last, path_end, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, point_count, run_last, path_end, output ready);
endinterface
`default_nettype wire

// ===== design/ccps_lerp.sv =====
// Shared lerp unit: registered (o - c) * ratio, then c + product >>> 16.
`default_nettype none
module ccps_lerp import ccps_pkg::*; (
  input  wire logic               clk,
  input  wire coord_t             c,
  input  wire coord_t             o,
  input  wire logic [RATIO_W-1:0] ratio,
  output coord_t                  res
);
  logic signed [COORD_WIDTH:0]            diff;
  logic signed [COORD_WIDTH+RATIO_W+1:0]  prod;
  logic signed [COORD_WIDTH+RATIO_W+1:0]  prod_r;
  coord_t                                 c_r;

  assign diff = $signed({o[COORD_WIDTH-1], o}) - $signed({c[COORD_WIDTH-1], c});
  assign prod = diff * $signed({1'b0, ratio});

  always_ff @(posedge clk) begin
    prod_r <= prod;
    c_r    <= c;
  end

  assign res = c_r + coord_t'(prod_r[COORD_WIDTH+15:16]);
endmodule
`default_nettype wire

// ===== design/corner_cutting_path_smoother.sv =====
// Top level: cascaded corner-cutting passes run by one sequencer and a shared lerp unit.
//
//  channel  dir  handshake     word
//  in_if    in   valid/ready   one point (in_x, in_y, in_z) and path_last
//  out_if   out  valid/ready   up to two points, point_count, run_last, path_end
//  cfg_*    in   we only       register index and data, no read-back
//
// Each point entering a stage goes through a feed, a pop and a return step; an interior point
// cut adds the lerp steps (lerp does one coordinate a cycle), for up to six passes.
// in_if.ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) clears all stage fill counts and the output valid flag.
// A full output register stalls the sequencer until the word is taken.
`default_nettype none
module corner_cutting_path_smoother import ccps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ccps_in_if.sink                    in_if,
  ccps_out_if.source                 out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FEED  = 5'b00010,
    S_MUL   = 5'b00100,
    S_NEXT  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t               state_r;
  logic                 enable_r;
  logic [LVL_W-1:0]     passes_r;
  logic [RATIO_W-1:0]   ratio_r;
  logic [LVL_W-1:0]     np;
  logic [RATIO_W-1:0]   ratio_sat;

  point_t               prev_r [MAX_PASSES];
  point_t               cur_r  [MAX_PASSES];
  logic [1:0]           fill_r [MAX_PASSES];
  point_t               qpt_r  [MAX_PASSES][QUEUE_DEPTH];
  logic                 qlast_r[MAX_PASSES][QUEUE_DEPTH];
  logic [1:0]           qlen_r [MAX_PASSES];
  logic [1:0]           qidx_r [MAX_PASSES];

  point_t               fq_r;
  logic                 fl_r;
  logic                 last_in_r;
  logic [LVL_W-1:0]     lvl_r;
  logic [2:0]           step_r;
  point_t               hold_a_r;
  point_t               hold_b_r;
  logic [1:0]           hold_n_r;
  logic                 out_valid_r;
  logic                 slot_free;
  logic                 emit;

  point_t               c_pt;
  point_t               a_pt;
  logic                 coin;
  logic [2:0]           wstep;
  logic [1:0]           wcoord;
  logic                 wentry;
  logic [1:0]           rcoord;
  coord_t               lerp_c;
  coord_t               lerp_o;
  coord_t               lerp_res;

  assign np = !enable_r ? 3'd0 : (passes_r > PASS_LIMIT ? PASS_LIMIT : passes_r);
  assign ratio_sat = (ratio_r < RATIO_MIN) ? RATIO_MIN :
                     (ratio_r > RATIO_MAX) ? RATIO_MAX : ratio_r;
  assign slot_free = !out_valid_r || out_if.ready;
  assign emit = slot_free && ((state_r == S_FEED && lvl_r == np && hold_n_r == 2'd2) ||
                              (state_r == S_FLUSH && hold_n_r != 2'd0));

  assign c_pt = cur_r[lvl_r];
  assign a_pt = prev_r[lvl_r];
  assign coin = (c_pt.x == a_pt.x && c_pt.y == a_pt.y) ||
                (c_pt.x == fq_r.x && c_pt.y == fq_r.y);

  assign rcoord = (step_r >= 3'd3) ? 2'(step_r - 3'd3) : step_r[1:0];
  assign lerp_c = coord_get(c_pt, rcoord);
  assign lerp_o = (step_r >= 3'd3) ? coord_get(fq_r, rcoord) : coord_get(a_pt, rcoord);
  assign wstep  = step_r - 3'd1;
  assign wentry = (wstep >= 3'd3);
  assign wcoord = wentry ? 2'(wstep - 3'd3) : wstep[1:0];

  ccps_lerp u_lerp (
    .clk   (clk),
    .c     (lerp_c),
    .o     (lerp_o),
    .ratio (ratio_sat),
    .res   (lerp_res)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      passes_r    <= 3'd1;
      ratio_r     <= RATIO_RESET;
      hold_n_r    <= 2'd0;
      lvl_r       <= '0;
      step_r      <= '0;
      for (int k = 0; k < MAX_PASSES; k++) begin
        fill_r[k] <= 2'd0;
        qlen_r[k] <= 2'd0;
        qidx_r[k] <= 2'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: enable_r <= cfg_data[0];
          REG_PASSES: passes_r <= cfg_data[LVL_W-1:0];
          REG_RATIO:  ratio_r  <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
        if (cfg_index == REG_ENABLE || cfg_index == REG_PASSES) begin
          for (int k = 0; k < MAX_PASSES; k++) fill_r[k] <= 2'd0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            fq_r      <= '{x: in_if.in_x, y: in_if.in_y, z: in_if.in_z};
            fl_r      <= in_if.path_last;
            last_in_r <= in_if.path_last;
            lvl_r     <= '0;
            state_r   <= S_FEED;
          end
        end
        S_FEED: begin
          if (lvl_r == np) begin
            // emit one point into the pair packer
            if (hold_n_r != 2'd2 || slot_free) begin
              if (hold_n_r == 2'd2) begin
                out_if.first_x     <= hold_a_r.x;
                out_if.first_y     <= hold_a_r.y;
                out_if.first_z     <= hold_a_r.z;
                out_if.second_x    <= hold_b_r.x;
                out_if.second_y    <= hold_b_r.y;
                out_if.second_z    <= hold_b_r.z;
                out_if.point_count <= 2'd2;
                out_if.run_last    <= 1'b0;
                out_if.path_end    <= 1'b0;
                hold_a_r           <= fq_r;
                hold_n_r           <= 2'd1;
              end else if (hold_n_r == 2'd1) begin
                hold_b_r <= fq_r;
                hold_n_r <= 2'd2;
              end else begin
                hold_a_r <= fq_r;
                hold_n_r <= 2'd1;
              end
              if (lvl_r == '0) begin
                state_r <= S_FLUSH;
              end else begin
                lvl_r   <= lvl_r - 3'd1;
                state_r <= S_NEXT;
              end
            end
          end else begin
            qidx_r[lvl_r] <= 2'd0;
            unique case (fill_r[lvl_r])
              2'd0: begin
                qpt_r[lvl_r][0]   <= fq_r;
                qlast_r[lvl_r][0] <= fl_r;
                qlen_r[lvl_r]     <= 2'd1;
                if (!fl_r) begin
                  prev_r[lvl_r] <= fq_r;
                  fill_r[lvl_r] <= 2'd1;
                end
                state_r <= S_NEXT;
              end
              2'd1: begin
                if (fl_r) begin
                  qpt_r[lvl_r][0]   <= fq_r;
                  qlast_r[lvl_r][0] <= 1'b1;
                  qlen_r[lvl_r]     <= 2'd1;
                  fill_r[lvl_r]     <= 2'd0;
                end else begin
                  cur_r[lvl_r]  <= fq_r;
                  fill_r[lvl_r] <= 2'd2;
                  qlen_r[lvl_r] <= 2'd0;
                end
                state_r <= S_NEXT;
              end
              default: begin
                if (coin) begin
                  qpt_r[lvl_r][0]   <= c_pt;
                  qlast_r[lvl_r][0] <= 1'b0;
                  if (fl_r) begin
                    qpt_r[lvl_r][1]   <= fq_r;
                    qlast_r[lvl_r][1] <= 1'b1;
                    qlen_r[lvl_r]     <= 2'd2;
                    fill_r[lvl_r]     <= 2'd0;
                  end else begin
                    qlen_r[lvl_r] <= 2'd1;
                    prev_r[lvl_r] <= c_pt;
                    cur_r[lvl_r]  <= fq_r;
                  end
                  state_r <= S_NEXT;
                end else begin
                  step_r  <= 3'd0;
                  state_r <= S_MUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          if (step_r != 3'd0) begin
            qpt_r[lvl_r][{1'b0, wentry}] <= coord_set(qpt_r[lvl_r][{1'b0, wentry}], wcoord,
                                                      lerp_res);
          end
          if (step_r == 3'd6) begin
            qlast_r[lvl_r][0] <= 1'b0;
            qlast_r[lvl_r][1] <= 1'b0;
            if (fl_r) begin
              qpt_r[lvl_r][2]   <= fq_r;
              qlast_r[lvl_r][2] <= 1'b1;
              qlen_r[lvl_r]     <= 2'd3;
              fill_r[lvl_r]     <= 2'd0;
            end else begin
              qlen_r[lvl_r] <= 2'd2;
              prev_r[lvl_r] <= c_pt;
              cur_r[lvl_r]  <= fq_r;
            end
            state_r <= S_NEXT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_NEXT: begin
          if (qidx_r[lvl_r] < qlen_r[lvl_r]) begin
            fq_r          <= qpt_r[lvl_r][qidx_r[lvl_r]];
            fl_r          <= qlast_r[lvl_r][qidx_r[lvl_r]];
            qidx_r[lvl_r] <= qidx_r[lvl_r] + 2'd1;
            lvl_r         <= lvl_r + 3'd1;
            state_r       <= S_FEED;
          end else if (lvl_r == '0) begin
            state_r <= S_FLUSH;
          end else begin
            lvl_r <= lvl_r - 3'd1;
          end
        end
        S_FLUSH: begin
          if (hold_n_r == 2'd0) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_if.first_x     <= hold_a_r.x;
            out_if.first_y     <= hold_a_r.y;
            out_if.first_z     <= hold_a_r.z;
            out_if.second_x    <= (hold_n_r == 2'd2) ? hold_b_r.x : '0;
            out_if.second_y    <= (hold_n_r == 2'd2) ? hold_b_r.y : '0;
            out_if.second_z    <= (hold_n_r == 2'd2) ? hold_b_r.z : '0;
            out_if.point_count <= hold_n_r;
            out_if.run_last    <= 1'b1;
            out_if.path_end    <= last_in_r;
            hold_n_r           <= 2'd0;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= np) else $error("stage level beyond pass count");
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_n_r != 2'd3) else $error("pair packer overfilled");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> hold_n_r == 2'd0) else $error("points left in packer");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> step_r <= 3'd6) else $error("lerp step overrun");
`endif
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for corner_cutting_path_smoother: directed and random paths, checked word by word.
`default_nettype none
module tb;
  import ccps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    point_t     p0;
    point_t     p1;
    logic [1:0] cnt;
    logic       run_last;
    logic       path_end;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ccps_in_if  in_if ();
  ccps_out_if out_if ();

  corner_cutting_path_smoother uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the block's registers and stage state
  logic                 sh_enable;
  logic [2:0]           sh_passes;
  logic [RATIO_W-1:0]   sh_ratio;
  point_t               stage_prev [MAX_PASSES];
  point_t               stage_cur [MAX_PASSES];
  int                   stage_fill [MAX_PASSES];
  point_t               cut_points [$];
  longint               ratio_eff;
  word_t                pending_words [$];
  int                   errors = 0;
  int                   burst_left = 0;
  int                   idle_count = 0;
  point_t               last_pt = '0;

  function automatic coord_t lerp_to(coord_t c, coord_t t);
    longint d;
    d = longint'(t) - longint'(c);
    return coord_t'(longint'(c) + ((d * ratio_eff) >>> 16));
  endfunction

  function automatic void cut_stage(int k, int np, point_t q, bit last);
    point_t a, c, t;
    if (k >= np) begin
      cut_points = {cut_points, q};
      return;
    end
    if (stage_fill[k] == 0) begin
      cut_stage(k + 1, np, q, last);
      if (!last) begin
        stage_prev[k] = q;
        stage_fill[k] = 1;
      end
    end else if (stage_fill[k] == 1) begin
      if (last) begin
        cut_stage(k + 1, np, q, 1'b1);
        stage_fill[k] = 0;
      end else begin
        stage_cur[k] = q;
        stage_fill[k] = 2;
      end
    end else begin
      a = stage_prev[k];
      c = stage_cur[k];
      if ((c.x == a.x && c.y == a.y) || (c.x == q.x && c.y == q.y)) begin
        cut_stage(k + 1, np, c, 1'b0);
      end else begin
        t.x = lerp_to(c.x, a.x); t.y = lerp_to(c.y, a.y); t.z = lerp_to(c.z, a.z);
        cut_stage(k + 1, np, t, 1'b0);
        t.x = lerp_to(c.x, q.x); t.y = lerp_to(c.y, q.y); t.z = lerp_to(c.z, q.z);
        cut_stage(k + 1, np, t, 1'b0);
      end
      if (last) begin
        cut_stage(k + 1, np, q, 1'b1);
        stage_fill[k] = 0;
      end else begin
        stage_prev[k] = c;
        stage_cur[k]  = q;
      end
    end
  endfunction

  function automatic void smooth_point(point_t p, bit last);
    int np;
    word_t w;
    np = (sh_passes > PASS_LIMIT) ? MAX_PASSES : int'(sh_passes);
    if (!sh_enable) np = 0;
    ratio_eff = (sh_ratio < RATIO_MIN) ? RATIO_MIN :
                (sh_ratio > RATIO_MAX) ? RATIO_MAX : sh_ratio;
    cut_points.delete();
    cut_stage(0, np, p, last);
    for (int i = 0; i < cut_points.size(); i += 2) begin
      w.p0 = cut_points[i];
      w.p1 = (i + 1 < cut_points.size()) ? cut_points[i + 1] : '0;
      w.cnt = (i + 1 < cut_points.size()) ? 2'd2 : 2'd1;
      w.run_last = (i + 2 >= cut_points.size());
      w.path_end = w.run_last && last;
      pending_words = {pending_words, w};
    end
  endfunction

  task automatic write_reg(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ENABLE: begin sh_enable = value[0]; foreach (stage_fill[k]) stage_fill[k] = 0; end
      REG_PASSES: begin sh_passes = value[2:0]; foreach (stage_fill[k]) stage_fill[k] = 0; end
      default:    sh_ratio = value[RATIO_W-1:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_words.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic configure(int en, int np, int r);
    drain();
    write_reg(REG_ENABLE, en);
    write_reg(REG_PASSES, np);
    write_reg(REG_RATIO, r);
  endtask

  task automatic send_point(point_t p, bit last);
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_if.valid = 1'b1;
    in_if.in_x = p.x; in_if.in_y = p.y; in_if.in_z = p.z; in_if.path_last = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    smooth_point(p, last);
    last_pt = p;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      2: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return coord_t'($urandom_range(0, 255)) <<< 16;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int kind;
    kind = $urandom_range(0, 9);
    kind = (kind < 2) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 2 : 3;
    p.x = rand_coord(kind); p.y = rand_coord(kind); p.z = rand_coord(kind);
    if ($urandom_range(0, 7) == 0) begin
      p.x = last_pt.x; p.y = last_pt.y;
    end
    return p;
  endfunction

  task automatic send_path(int len);
    for (int i = 0; i < len; i++) send_point(rand_point(), i == len - 1);
  endtask

  function automatic point_t mk(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    return p;
  endfunction

  task automatic test_reset_defaults();
    send_point(mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000), 1'b0);
    send_point(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF), 1'b0);
    send_point(mk(32'sh00010000, -32'sh00010000, 0), 1'b0);
    send_point(mk(0, 0, 32'sh7FFFFFFF), 1'b1);
  endtask

  task automatic test_passthrough();
    configure(0, 3, 16384);
    send_path(3);
    configure(1, 0, 16384);
    send_path(2);
  endtask

  task automatic test_short_paths();
    configure(1, 2, 9000);
    send_path(1);
    send_path(2);
  endtask

  task automatic test_coincident();
    configure(1, 1, 16384);
    send_point(mk(32'sh10000, 32'sh20000, 5), 1'b0);
    send_point(mk(32'sh10000, 32'sh20000, 7), 1'b0);
    send_point(mk(32'sh30000, 32'sh20000, 9), 1'b0);
    send_point(mk(32'sh30000, 32'sh20000, 1), 1'b1);
  endtask

  task automatic test_ratio_extremes();
    configure(1, 1, 0);
    send_path(3);
    configure(1, 1, 32767);
    send_path(3);
  endtask

  task automatic test_deep_passes();
    configure(1, 7, 29491);
    send_path(4);
  endtask

  task automatic test_abandoned_path();
    configure(1, 2, 1311);
    send_point(rand_point(), 1'b0);
    send_point(rand_point(), 1'b0);
    configure(1, 3, 1311);
    send_path(3);
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 420) begin
      if ($urandom_range(0, 5) == 0) begin
        configure($urandom_range(0, 9) != 0, ($urandom_range(0, 4) == 0) ?
                  $urandom_range(4, 7) : $urandom_range(0, 3), $urandom_range(0, 32767));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      if ($urandom_range(0, 15) == 0) begin
        for (int i = 0; i < len; i++) send_point(rand_point(), $urandom_range(0, 3) == 0);
      end else begin
        send_path(len);
      end
      sent += len;
    end
  endtask

  always @(negedge clk) begin
    case (($time / 4000) % 3)
      0: out_if.ready = 1'b1;
      1: out_if.ready = ($urandom_range(0, 1) == 1);
      default: out_if.ready = ($urandom_range(0, 15) > 11);
    endcase
  end

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word exp=none act=%h %h", $time,
                 {out_if.first_x, out_if.first_y, out_if.first_z}, out_if.point_count);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_if.first_x !== w.p0.x || out_if.first_y !== w.p0.y ||
            out_if.first_z !== w.p0.z) begin
          $display("%0t: first point exp=%h act=%h", $time, w.p0,
                   {out_if.first_x, out_if.first_y, out_if.first_z});
          errors++;
        end
        if (out_if.second_x !== w.p1.x || out_if.second_y !== w.p1.y ||
            out_if.second_z !== w.p1.z) begin
          $display("%0t: second point exp=%h act=%h", $time, w.p1,
                   {out_if.second_x, out_if.second_y, out_if.second_z});
          errors++;
        end
        if (out_if.point_count !== w.cnt) begin
          $display("%0t: point_count exp=%0d act=%0d", $time, w.cnt, out_if.point_count);
          errors++;
        end
        if (out_if.run_last !== w.run_last) begin
          $display("%0t: run_last exp=%b act=%b", $time, w.run_last, out_if.run_last);
          errors++;
        end
        if (out_if.path_end !== w.path_end) begin
          $display("%0t: path_end exp=%b act=%b", $time, w.path_end, out_if.path_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.in_x = '0; in_if.in_y = '0; in_if.in_z = '0; in_if.path_last = 1'b0;
    out_if.ready = 1'b0;
    sh_enable = 1'b1; sh_passes = 3'd1; sh_ratio = RATIO_RESET;
    foreach (stage_fill[k]) stage_fill[k] = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_passthrough();
    test_short_paths();
    test_coincident();
    test_ratio_extremes();
    test_deep_passes();
    test_abandoned_path();
    test_random();
    drain();
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== corner_cutting_path_smoother.f =====
design/ccps_pkg.sv
design/ccps_if.sv
design/ccps_lerp.sv
design/corner_cutting_path_smoother.sv
bench/tb.sv
